FILE: rtl/sh9_pkg.sv
// Shared widths, term codes and pipeline tag type for the SH9 shading block.
package sh9_pkg;

  localparam int SH_TERMS = 9;
  localparam int TERM_W = $clog2(SH_TERMS);
  localparam int MAX_COLORS = 3;
  localparam int COLOR_CHANNELS_DEF = 3;
  localparam int COL_W = 2;

  localparam int IDX_W = 5;
  localparam int COEF_W = 16;
  localparam int NORM_W = 16;
  localparam int WEIGHT_W = 32;
  localparam int BASIS_W = 36;

  localparam int IN_DATA_W = 72;
  localparam int OUT_DATA_W = MAX_COLORS * WEIGHT_W;

  // request kinds carried on s_tuser
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_SHADE = 1'b1;

  // basis term codes
  localparam logic [TERM_W-1:0] T_CONST = 4'd0;
  localparam logic [TERM_W-1:0] T_Y = 4'd1;
  localparam logic [TERM_W-1:0] T_Z = 4'd2;
  localparam logic [TERM_W-1:0] T_X = 4'd3;
  localparam logic [TERM_W-1:0] T_XY = 4'd4;
  localparam logic [TERM_W-1:0] T_YZ = 4'd5;
  localparam logic [TERM_W-1:0] T_ZZ = 4'd6;
  localparam logic [TERM_W-1:0] T_XZ = 4'd7;
  localparam logic [TERM_W-1:0] T_XXYY = 4'd8;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } tag_t;

endpackage

FILE: rtl/sh9_rgb_shading.sv
// Top level: order-2 spherical-harmonic RGB shading with a coefficient RAM.
// Shade transfer: accept to m_tvalid (the nine basis terms are issued in turn
// through the shared basis pipe and color MAC lanes, then the pipe drains, and
// the result waits for a free output). Load transfer: read-modify-write of one
// coefficient row; no result. One item in flight: the next accept follows the
// end of a shade or load; a new item is taken while a result waits on the output.
// Reset (rst, synchronous): all coefficients read as zero, output empty.
module sh9_rgb_shading #(
  parameter int COLOR_CHANNELS = sh9_pkg::COLOR_CHANNELS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // coef_index[4:0], coef_value[20:5], normal_x[36:21], normal_y[52:37], normal_z[68:53]
  input  logic [sh9_pkg::IN_DATA_W-1:0]    s_tdata,
  // req_type
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // red_weight[31:0], green_weight[63:32], blue_weight[95:64]
  output logic [sh9_pkg::OUT_DATA_W-1:0]   m_tdata
);
  import sh9_pkg::*;

  localparam int ROW_W = COLOR_CHANNELS * COEF_W;
  localparam int DEPTH = COLOR_CHANNELS * SH_TERMS;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_ISSUE = 3'd2;
  localparam logic [2:0] ST_WAIT = 3'd3;
  localparam logic [2:0] ST_FIN = 3'd4;

  logic [2:0] state;
  logic [TERM_W-1:0] term;
  logic [SH_TERMS-1:0] row_valid;
  logic rd_valid;

  logic [IDX_W-1:0] in_idx;
  logic [COEF_W-1:0] in_value;
  logic [COL_W-1:0] in_col;
  logic [TERM_W-1:0] in_row;
  logic in_hit;
  logic accept;

  logic [COL_W-1:0] ld_col;
  logic [TERM_W-1:0] ld_row;
  logic [COEF_W-1:0] ld_value;
  logic signed [NORM_W-1:0] nx, ny, nz;

  logic [TERM_W-1:0] raddr, lookup_term;
  logic [ROW_W-1:0] rdata, coef_row, merged_row;
  logic we;

  logic signed [BASIS_W-1:0] basis;
  tag_t tag;
  logic [COLOR_CHANNELS*WEIGHT_W-1:0] weight;
  logic mac_done;
  logic out_free;

  assign s_tready = (state == ST_IDLE);
  assign accept = s_tvalid && s_tready;
  assign in_idx = s_tdata[4:0];
  assign in_value = s_tdata[20:5];
  assign out_free = !m_tvalid || m_tready;

  // slot = color*9 + term
  always_comb begin
    logic [IDX_W-1:0] rem;
    rem = in_idx;
    in_col = '0;
    for (int c = 1; c < COLOR_CHANNELS; c++) begin
      if (in_idx >= IDX_W'(c * SH_TERMS)) begin
        in_col = COL_W'(c);
        rem = in_idx - IDX_W'(c * SH_TERMS);
      end
    end
    in_row = rem[TERM_W-1:0];
    in_hit = (in_idx < IDX_W'(DEPTH));
  end

  assign raddr = (state == ST_IDLE) ? in_row : lookup_term;
  assign coef_row = rd_valid ? rdata : '0;
  assign we = (state == ST_LOAD);

  always_comb begin
    merged_row = coef_row;
    for (int c = 0; c < COLOR_CHANNELS; c++) begin
      if (ld_col == COL_W'(c)) begin
        merged_row[c*COEF_W +: COEF_W] = ld_value;
      end
    end
  end

  sh9_ram #(
    .WIDTH(ROW_W),
    .DEPTH(SH_TERMS)
  ) u_coef_ram (
    .clk  (clk),
    .we   (we),
    .waddr(ld_row),
    .wdata(merged_row),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= (raddr < TERM_W'(SH_TERMS)) ? row_valid[raddr] : 1'b0;
    end
  end

  sh9_basis u_basis (
    .clk        (clk),
    .rst        (rst),
    .issue      (state == ST_ISSUE),
    .issue_term (term),
    .nx         (nx),
    .ny         (ny),
    .nz         (nz),
    .lookup_term(lookup_term),
    .basis      (basis),
    .tag        (tag)
  );

  sh9_mac #(
    .COLORS(COLOR_CHANNELS)
  ) u_mac (
    .clk     (clk),
    .rst     (rst),
    .basis   (basis),
    .coef_row(coef_row),
    .tag_in  (tag),
    .weight  (weight),
    .done    (mac_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      term <= '0;
      row_valid <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          term <= '0;
          if (accept) begin
            if (s_tuser == REQ_LOAD) begin
              if (in_hit) begin
                state <= ST_LOAD;
              end
            end else begin
              state <= ST_ISSUE;
            end
          end
        end
        ST_LOAD: begin
          row_valid[ld_row] <= 1'b1;
          state <= ST_IDLE;
        end
        ST_ISSUE: begin
          term <= term + 1'b1;
          if (term == T_XXYY) begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (mac_done) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ld_col <= in_col;
      ld_row <= in_row;
      ld_value <= in_value;
      nx <= s_tdata[36:21];
      ny <= s_tdata[52:37];
      nz <= s_tdata[68:53];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // absent colors read as zero
  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      m_tdata <= OUT_DATA_W'(weight);
    end
  end

endmodule

FILE: rtl/sh9_ram.sv
// Generic simple dual-port RAM with registered read.
module sh9_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 9,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/sh9_basis.sv
// Three-stage basis generator: normal product, constant scale, rounding.
module sh9_basis (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              issue,
  input  logic [sh9_pkg::TERM_W-1:0]        issue_term,
  input  logic signed [sh9_pkg::NORM_W-1:0] nx,
  input  logic signed [sh9_pkg::NORM_W-1:0] ny,
  input  logic signed [sh9_pkg::NORM_W-1:0] nz,
  output logic [sh9_pkg::TERM_W-1:0]        lookup_term,
  output logic signed [sh9_pkg::BASIS_W-1:0] basis,
  output sh9_pkg::tag_t                     tag
);
  import sh9_pkg::*;

  localparam int OP_W = 18;
  localparam int Q_W = 36;
  localparam int K_W = 18;
  localparam int M_W = Q_W + K_W + 1;

  // Q.16 scale constants
  localparam logic [K_W-1:0] K_C0 = 18'd58080;
  localparam logic [K_W-1:0] K_C1 = 18'd116160;
  localparam logic [K_W-1:0] K_K2 = 18'd159058;
  localparam logic [K_W-1:0] K_C6 = 18'd45916;
  localparam logic [K_W-1:0] K_C8 = 18'd79529;

  function automatic logic [K_W-1:0] term_const(input logic [TERM_W-1:0] t);
    logic [K_W-1:0] k;
    case (t)
      T_CONST: k = K_C0;
      T_Y, T_Z, T_X: k = K_C1;
      T_XY, T_YZ, T_XZ: k = K_K2;
      T_ZZ: k = K_C6;
      T_XXYY: k = K_C8;
      default: k = '0;
    endcase
    return k;
  endfunction

  logic signed [OP_W-1:0] xs, ys, zs, op_a, op_b;
  logic signed [Q_W-1:0] offset;

  logic signed [Q_W-1:0] q;
  logic [TERM_W-1:0] term1;
  logic shift1;
  tag_t tag1;

  logic signed [M_W-1:0] m;
  logic shift2;
  tag_t tag2;

  always_comb begin
    xs = OP_W'(nx);
    ys = OP_W'(ny);
    zs = OP_W'(nz);
    op_a = '0;
    op_b = OP_W'(1);
    offset = '0;
    case (issue_term)
      T_CONST: op_a = OP_W'(16384);
      T_Y: op_a = -ys;
      T_Z: op_a = zs;
      T_X: op_a = -xs;
      T_XY: begin
        op_a = xs;
        op_b = ys;
      end
      T_YZ: begin
        op_a = -ys;
        op_b = zs;
      end
      T_ZZ: begin
        op_a = zs + (zs <<< 1);
        op_b = zs;
        offset = Q_W'(64'sd268435456);
      end
      T_XZ: begin
        op_a = -xs;
        op_b = zs;
      end
      T_XXYY: begin
        op_a = xs + ys;
        op_b = xs - ys;
      end
      default: begin
        op_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
      tag2 <= '0;
      tag <= '0;
    end else begin
      tag1.valid <= issue;
      tag1.first <= (issue_term == T_CONST);
      tag1.last <= (issue_term == T_XXYY);
      tag2 <= tag1;
      tag <= tag2;
    end
  end

  always_ff @(posedge clk) begin
    q <= Q_W'(op_a * op_b) - offset;
    term1 <= issue_term;
    shift1 <= (issue_term >= T_XY);

    m <= q * $signed({1'b0, term_const(term1)});
    lookup_term <= term1;
    shift2 <= shift1;

    // quadratic terms round half up from Q.44 to Q.30
    if (shift2) begin
      basis <= BASIS_W'((m + M_W'(8192)) >>> 14);
    end else begin
      basis <= BASIS_W'(m);
    end
  end

endmodule

FILE: rtl/sh9_mac.sv
// Per-color multiply-accumulate lanes with final rounding and saturation.
module sh9_mac #(
  parameter int COLORS = sh9_pkg::COLOR_CHANNELS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic signed [sh9_pkg::BASIS_W-1:0] basis,
  input  logic [COLORS*sh9_pkg::COEF_W-1:0]  coef_row,
  input  sh9_pkg::tag_t                      tag_in,
  output logic [COLORS*sh9_pkg::WEIGHT_W-1:0] weight,
  output logic                               done
);
  import sh9_pkg::*;

  localparam int PROD_W = BASIS_W + COEF_W;
  localparam int ACC_W = 56;

  logic signed [PROD_W-1:0] prod [COLORS];
  logic signed [ACC_W-1:0] acc [COLORS];
  tag_t tag1;

  function automatic logic [WEIGHT_W-1:0] round_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] r;
    logic [WEIGHT_W-1:0] w;
    r = (a + ACC_W'(33554432)) >>> 26;
    if (r > ACC_W'(64'sd2147483647)) begin
      w = 32'h7FFF_FFFF;
    end else if (r < -ACC_W'(64'sd2147483648)) begin
      w = 32'h8000_0000;
    end else begin
      w = r[WEIGHT_W-1:0];
    end
    return w;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
      done <= 1'b0;
    end else begin
      tag1 <= tag_in;
      done <= tag1.valid && tag1.last;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < COLORS; c++) begin
      prod[c] <= basis * $signed(coef_row[c*COEF_W +: COEF_W]);
      if (tag1.valid) begin
        if (tag1.first) begin
          acc[c] <= ACC_W'(prod[c]);
        end else begin
          acc[c] <= acc[c] + ACC_W'(prod[c]);
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < COLORS; c++) begin
      weight[c*WEIGHT_W +: WEIGHT_W] = round_sat(acc[c]);
    end
  end

endmodule
